FILE: hw/rtl/gcs_pkg.sv
`timescale 1ns / 1ps

package gcs_pkg;

	localparam int COLOR_W  = 8;
	localparam int DIST_W   = 18;
	localparam int WEIGHT_W = 21;
	localparam int COST_W   = 24;
	localparam int PEN_W    = 20;
	localparam int IMG_W_W  = 11;
	localparam int IMG_H_W  = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TERMINAL_COST = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BAD_PENALTY   = 2'd3;

	localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST   = 11'd1024;
	localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST  = 16'd1024;
	localparam logic [COST_W-1:0]  TERMINAL_COST_RST = 24'd10000;
	localparam logic [PEN_W-1:0]   BAD_PENALTY_RST   = 20'd1000;

	// per-pixel record kept for the neighbours: color distance and both-masks bit
	typedef struct packed {
		logic              ok;
		logic [DIST_W-1:0] sqd;
	} px_t;

	localparam int PX_W = $bits(px_t);

	function automatic logic [2*COLOR_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
		input logic [COLOR_W-1:0] b);
		logic [COLOR_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return d * d;
	endfunction

endpackage

FILE: hw/rtl/graph_cut_seam_edge_weights.sv
`timescale 1ns / 1ps

// Graph-cut seam edge weights. Pixel pairs of two overlapping RGB images enter in raster
// order; each transfer yields one result carrying the pixel's source/sink terminal weights
// and the weights of the edges to its left and upper neighbours (squared color distances
// summed plus one, plus the penalty where a mask is clear). Throughput is one pixel per
// clock unless stalled, set by a single input stage and a single output register; the
// previous row lives in a MAX_WIDTH-deep RAM read at the pixel's column on acceptance and
// written back as the pixel leaves, with a bypass for one-wide rows. Configuration is to be
// written only between frames or while no pixel is in flight; the block does not enforce
// this. Width zero acts as one, widths above MAX_WIDTH as MAX_WIDTH, height zero as one.

module graph_cut_seam_edge_weights import gcs_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  s_tvalid,
	output logic                  s_tready,
	// a_red, a_green, a_blue, b_red, b_green, b_blue
	input  logic [47:0]           s_tdata,
	// mask_a, mask_b
	input  logic [1:0]            s_tuser,

	output logic                  m_tvalid,
	input  logic                  m_tready,
	// source_weight, sink_weight, left_weight, up_weight, zero pad
	output logic [95:0]           m_tdata,
	// left_valid, up_valid
	output logic [1:0]            m_tuser,
	output logic                  m_tlast
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;

	// configuration
	logic [IMG_W_W-1:0] img_width_q;
	logic [IMG_H_W-1:0] img_height_q;
	logic [COST_W-1:0]  term_cost_q;
	logic [PEN_W-1:0]   penalty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width_q  <= IMAGE_WIDTH_RST;
			img_height_q <= IMAGE_HEIGHT_RST;
			term_cost_q  <= TERMINAL_COST_RST;
			penalty_q    <= BAD_PENALTY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:   img_width_q  <= cfg_data[IMG_W_W-1:0];
				REG_IMAGE_HEIGHT:  img_height_q <= cfg_data[IMG_H_W-1:0];
				REG_TERMINAL_COST: term_cost_q  <= cfg_data[COST_W-1:0];
				REG_BAD_PENALTY:   penalty_q    <= cfg_data[PEN_W-1:0];
				default: ;
			endcase
		end
	end

	// raster position
	logic [CW-1:0]      col_q;
	logic [IMG_H_W-1:0] row_q;
	logic [WW-1:0]      width_ext;
	logic [WW-1:0]      width_eff;
	logic [CW-1:0]      width_m1;
	logic [IMG_H_W-1:0] height_m1;
	logic [CW-1:0]      col_cur;
	logic               last_col;
	logic               last_row;

	always_comb begin
		width_ext = WW'(img_width_q);
		if (width_ext == '0) begin
			width_eff = WW'(1);
		end else if (width_ext > WW'(MAX_WIDTH)) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = width_ext;
		end
	end

	assign width_m1  = CW'(width_eff - WW'(1));
	assign height_m1 = (img_height_q == '0) ? '0 : img_height_q - IMG_H_W'(1);
	assign col_cur   = (col_q > width_m1) ? width_m1 : col_q;
	assign last_col  = (col_cur >= width_m1);
	assign last_row  = (row_q >= height_m1);

	// handshake
	logic s1_valid_q;
	logic m_valid_q;
	logic s1_move;
	logic s_accept;

	assign s1_move  = s1_valid_q && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_move;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (s_accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + IMG_H_W'(1);
			end else begin
				col_q <= col_cur + CW'(1);
			end
		end
	end

	// input stage
	logic [47:0]   data_s1;
	logic          mask_a_s1;
	logic          mask_b_s1;
	logic [CW-1:0] col_s1;
	logic          left_valid_s1;
	logic          up_valid_s1;
	logic          last_s1;
	logic          fwd_s1;
	px_t           fwd_px_s1;
	px_t           here;
	px_t           prev_q;
	px_t           up_px;
	logic [PX_W-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			data_s1       <= s_tdata;
			mask_a_s1     <= s_tuser[0];
			mask_b_s1     <= s_tuser[1];
			col_s1        <= col_cur;
			left_valid_s1 <= (col_cur != '0);
			up_valid_s1   <= (row_q != '0);
			last_s1       <= last_col && last_row;
			// row store written this same edge at the column being read
			fwd_s1        <= s1_move && (col_s1 == col_cur);
			fwd_px_s1     <= here;
		end
	end

	gcs_ram #(
		.WIDTH(PX_W),
		.DEPTH(MAX_WIDTH)
	) u_row_store (
		.clk  (clk),
		.we   (s1_move),
		.waddr(col_s1),
		.wdata(here),
		.re   (s_accept),
		.raddr(col_cur),
		.rdata(ram_rdata)
	);

	assign up_px = fwd_s1 ? fwd_px_s1 : px_t'(ram_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (s1_move) begin
			prev_q <= here;
		end
	end

	logic [WEIGHT_W-1:0] left_w;
	logic [WEIGHT_W-1:0] up_w;

	gcs_cost u_cost (
		.a_red      (data_s1[7:0]),
		.a_green    (data_s1[15:8]),
		.a_blue     (data_s1[23:16]),
		.b_red      (data_s1[31:24]),
		.b_green    (data_s1[39:32]),
		.b_blue     (data_s1[47:40]),
		.mask_a     (mask_a_s1),
		.mask_b     (mask_b_s1),
		.left_valid (left_valid_s1),
		.up_valid   (up_valid_s1),
		.left_px    (prev_q),
		.up_px      (up_px),
		.penalty    (penalty_q),
		.here       (here),
		.left_weight(left_w),
		.up_weight  (up_w)
	);

	// output register
	logic [95:0] m_data_q;
	logic [1:0]  m_user_q;
	logic        m_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_move) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			m_data_q <= {6'd0, up_w, left_w,
				(mask_b_s1 ? term_cost_q : COST_W'(0)),
				(mask_a_s1 ? term_cost_q : COST_W'(0))};
			m_user_q <= {up_valid_s1, left_valid_s1};
			m_last_q <= last_s1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

	// checks
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && m_valid_q && !m_tready) |-> !s_tready)
		else $error("input taken while both stages are stalled");

	a_frame_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && last_col && last_row) |=> (col_q == '0 && row_q == '0))
		else $error("raster position not cleared after the last pixel");

	a_first_col_no_left: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && col_cur == '0) |=> !left_valid_s1)
		else $error("left edge reported in the first column");

	a_fwd_only_on_move: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && !s1_move) |=> !fwd_s1)
		else $error("row store bypass without a write-back");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> (col_s1 <= width_m1))
		else $error("column beyond the row");

endmodule

FILE: hw/rtl/gcs_ram.sv
`timescale 1ns / 1ps

module gcs_ram #(
	parameter int WIDTH = 19,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/gcs_cost.sv
`timescale 1ns / 1ps

module gcs_cost import gcs_pkg::*; (
	input  logic [COLOR_W-1:0]  a_red,
	input  logic [COLOR_W-1:0]  a_green,
	input  logic [COLOR_W-1:0]  a_blue,
	input  logic [COLOR_W-1:0]  b_red,
	input  logic [COLOR_W-1:0]  b_green,
	input  logic [COLOR_W-1:0]  b_blue,
	input  logic                mask_a,
	input  logic                mask_b,
	input  logic                left_valid,
	input  logic                up_valid,
	input  px_t                 left_px,
	input  px_t                 up_px,
	input  logic [PEN_W-1:0]    penalty,
	output px_t                 here,
	output logic [WEIGHT_W-1:0] left_weight,
	output logic [WEIGHT_W-1:0] up_weight
);

	logic [DIST_W-1:0]   sqd_sum;
	logic [WEIGHT_W-1:0] left_raw;
	logic [WEIGHT_W-1:0] up_raw;

	function automatic logic [WEIGHT_W-1:0] edge_w(input px_t p, input px_t q,
		input logic [PEN_W-1:0] pen);
		logic [WEIGHT_W-1:0] w;
		w = WEIGHT_W'(p.sqd) + WEIGHT_W'(q.sqd) + WEIGHT_W'(1);
		if (!p.ok || !q.ok) begin
			w = w + WEIGHT_W'(pen);
		end
		return w;
	endfunction

	assign sqd_sum = DIST_W'(sq_diff(a_red, b_red)) + DIST_W'(sq_diff(a_green, b_green))
		+ DIST_W'(sq_diff(a_blue, b_blue));

	assign here.sqd = sqd_sum;
	assign here.ok  = mask_a & mask_b;

	assign left_raw = edge_w(here, left_px, penalty);
	assign up_raw   = edge_w(here, up_px, penalty);

	assign left_weight = left_valid ? left_raw : '0;
	assign up_weight   = up_valid ? up_raw : '0;

endmodule

FILE: test/tb_graph_cut_seam_edge_weights.sv
`timescale 1ns / 1ps

module tb_graph_cut_seam_edge_weights;
	import gcs_pkg::*;

	localparam int MAX_WIDTH   = 1024;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [7:0] ar, ag, ab, br, bg, bb;
		logic       ma, mb;
	} pixel_t;

	typedef struct packed {
		logic [COST_W-1:0]   src;
		logic [COST_W-1:0]   snk;
		logic [WEIGHT_W-1:0] lw;
		logic                lv;
		logic [WEIGHT_W-1:0] uw;
		logic                uv;
		logic                last;
	} weights_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [47:0]           s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [95:0]           m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;

	// mirror of the block's registers and neighbour state
	logic [IMG_W_W-1:0] width_reg;
	logic [IMG_H_W-1:0] height_reg;
	logic [COST_W-1:0]  cost_reg;
	logic [PEN_W-1:0]   pen_reg;
	px_t                line_mem [MAX_WIDTH];
	bit                 line_filled [MAX_WIDTH];
	px_t                left_px;
	int unsigned        col_cnt;
	int unsigned        row_cnt;

	weights_t expected_q [$];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int errors;
	int items_sent;
	int results_checked;
	int frames_seen;
	int settings_used;
	int stall_cycles;

	graph_cut_seam_edge_weights #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned eff_width(logic [IMG_W_W-1:0] w);
		if (w == 0)
			return 1;
		if (w > MAX_WIDTH)
			return MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned chan_sq(logic [7:0] a, logic [7:0] b);
		int d;
		d = int'(a) - int'(b);
		return d * d;
	endfunction

	function automatic logic [WEIGHT_W-1:0] link_weight(px_t a, px_t b);
		int unsigned w;
		w = a.sqd + b.sqd + 1;
		if (!(a.ok && b.ok))
			w += pen_reg;
		return w[WEIGHT_W-1:0];
	endfunction

	function automatic weights_t predict_weights(pixel_t p);
		weights_t    r;
		px_t         cur;
		int unsigned w, h, col;
		logic        lc, lr;
		w = eff_width(width_reg);
		h = (height_reg == 0) ? 1 : height_reg;
		col = (col_cnt > w - 1) ? w - 1 : col_cnt;
		cur.ok = p.ma & p.mb;
		cur.sqd = DIST_W'(chan_sq(p.ar, p.br) + chan_sq(p.ag, p.bg) + chan_sq(p.ab, p.bb));
		r.src = p.ma ? cost_reg : '0;
		r.snk = p.mb ? cost_reg : '0;
		r.lv = (col > 0);
		r.lw = r.lv ? link_weight(cur, left_px) : '0;
		r.uv = (row_cnt > 0);
		r.uw = r.uv ? link_weight(cur, line_mem[col]) : '0;
		lc = (col >= w - 1);
		lr = (row_cnt >= h - 1);
		r.last = lc && lr;
		line_mem[col] = cur;
		line_filled[col] = 1'b1;
		left_px = cur;
		if (lc) begin
			col_cnt = 0;
			row_cnt = lr ? 0 : ((row_cnt + 1) & 16'hFFFF);
		end else begin
			col_cnt = col + 1;
		end
		return r;
	endfunction

	function automatic pixel_t mk_pixel(logic [7:0] ar, logic [7:0] ag, logic [7:0] ab,
		logic [7:0] br, logic [7:0] bg, logic [7:0] bb, logic ma, logic mb);
		pixel_t p;
		p.ar = ar; p.ag = ag; p.ab = ab;
		p.br = br; p.bg = bg; p.bb = bb;
		p.ma = ma; p.mb = mb;
		return p;
	endfunction

	function automatic logic [7:0] rand_chan();
		if ($urandom_range(9) == 0)
			return $urandom_range(1) ? 8'hFF : 8'h00;
		return 8'($urandom);
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t p;
		p = mk_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(), rand_chan(),
			rand_chan(), 1'b1, 1'b1);
		// mostly inside both images, some pixels in the bad region
		if ($urandom_range(9) < 4) begin
			p.ma = 1'($urandom);
			p.mb = 1'($urandom);
		end
		return p;
	endfunction

	// called at a falling edge; returns at a falling edge with tvalid low
	task automatic send_pixel(input pixel_t p);
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		s_tdata = {p.bb, p.bg, p.br, p.ab, p.ag, p.ar};
		s_tuser = {p.mb, p.ma};
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		expected_q.push_back(predict_weights(p));
		items_sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic wait_idle();
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = CFG_DATA_W'(value);
		case (idx)
			REG_IMAGE_WIDTH: begin
				width_reg = IMG_W_W'(value);
			end
			REG_IMAGE_HEIGHT: begin
				height_reg = IMG_H_W'(value);
			end
			REG_TERMINAL_COST: begin
				cost_reg = COST_W'(value);
			end
			REG_BAD_PENALTY: begin
				pen_reg = PEN_W'(value);
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Width growth while below the first row would read line entries never stored;
	// such a frame is closed first by one pixel under a one-wide, one-high setting.
	task automatic set_frame(input int unsigned w, input int unsigned h,
		input int unsigned cost, input int unsigned pen);
		bit hazard;
		hazard = 1'b0;
		wait_idle();
		if (row_cnt != 0)
			for (int i = 0; i < eff_width(IMG_W_W'(w)); i++)
				if (!line_filled[i])
					hazard = 1'b1;
		if (hazard) begin
			write_reg(REG_IMAGE_HEIGHT, 1);
			write_reg(REG_IMAGE_WIDTH, 1);
			send_pixel(rand_pixel());
			wait_idle();
		end
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_TERMINAL_COST, cost);
		write_reg(REG_BAD_PENALTY, pen);
		write_reg(REG_IMAGE_WIDTH, w);
		settings_used++;
	endtask

	task automatic test_reset_values();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
		send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
		send_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
		send_pixel(mk_pixel(8'h55, 8'hAA, 8'h0F, 8'hAA, 8'h55, 8'hF0, 1'b1, 1'b0));
		send_pixel(mk_pixel(8'h12, 8'h34, 8'h56, 8'h12, 8'h34, 8'h56, 1'b0, 1'b1));
	endtask

	// width shrinks while the first row is under way: the column clamps and the row ends
	task automatic test_midframe_shrink();
		set_frame(4, 2, 10000, 1000);
		repeat (5) send_pixel(rand_pixel());
	endtask

	task automatic test_extreme_weights();
		set_frame(3, 2, 24'hFFFFFF, 20'hFFFFF);
		for (int i = 0; i < 6; i++)
			if (i % 2 == 0)
				send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
			else
				send_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1));
		set_frame(2, 1, 0, 0);
		send_pixel(mk_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b1));
		send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0));
	endtask

	task automatic test_width_clamp();
		set_frame(2047, 2, 777, 33);
		repeat (3) send_pixel(rand_pixel());
		// zero width acts as one: clamps the running column, row 1 reads column 0
		set_frame(0, 2, 777, 33);
		repeat (3) send_pixel(rand_pixel());
	endtask

	task automatic test_height_extremes();
		set_frame(1, 65535, 5, 9);
		repeat (8) send_pixel(rand_pixel());
		set_frame(1, 0, 5, 9);
		repeat (2) send_pixel(rand_pixel());
	endtask

	task automatic random_settings();
		int unsigned w, h, cost, pen;
		case ($urandom_range(19))
			0: w = 0;
			1: w = MAX_WIDTH;
			2: w = 2047;
			3, 4, 5: w = $urandom_range(64, 17);
			default: w = $urandom_range(16, 1);
		endcase
		case ($urandom_range(9))
			0: h = 0;
			1: h = 65535;
			default: h = $urandom_range(8, 1);
		endcase
		case ($urandom_range(7))
			0: cost = 0;
			1: cost = 24'hFFFFFF;
			default: cost = $urandom & 24'hFFFFFF;
		endcase
		case ($urandom_range(7))
			0: pen = 0;
			1: pen = 20'hFFFFF;
			default: pen = $urandom & 20'hFFFFF;
		endcase
		set_frame(w, h, cost, pen);
	endtask

	task automatic test_random_phase(input int sidle, input int ridle, input int n);
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		for (int k = 0; k < 3; k++) begin
			random_settings();
			repeat (n / 3) send_pixel(rand_pixel());
		end
		wait_idle();
	endtask

	task automatic test_output_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_frame(5, 3, 4321, 123);
		hold_left = 300;
		repeat (30) send_pixel(rand_pixel());
		wait_idle();
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready = 1'b0;
				hold_left--;
			end else begin
				m_tready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : check_results
		weights_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.src = m_tdata[23:0];
			got.snk = m_tdata[47:24];
			got.lw = m_tdata[68:48];
			got.uw = m_tdata[89:69];
			got.lv = m_tuser[0];
			got.uv = m_tuser[1];
			got.last = m_tlast;
			if (got.last)
				frames_seen++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result transfer: src=%0d snk=%0d left=%0d/%0b up=%0d/%0b last=%0b",
						got.src, got.snk, got.lw, got.lv, got.uw, got.uv, got.last);
			end else begin
				want = expected_q.pop_front();
				results_checked++;
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch at result %0d: exp src=%0d snk=%0d left=%0d/%0b ",
							"up=%0d/%0b last=%0b, got src=%0d snk=%0d left=%0d/%0b ",
							"up=%0d/%0b last=%0b"}, results_checked,
							want.src, want.snk, want.lw, want.lv, want.uw, want.uv, want.last,
							got.src, got.snk, got.lw, got.lv, got.uw, got.uv, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("tb_graph_cut_seam_edge_weights failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 0;
		errors = 0;
		items_sent = 0;
		results_checked = 0;
		frames_seen = 0;
		settings_used = 0;
		stall_cycles = 0;
		width_reg = IMAGE_WIDTH_RST;
		height_reg = IMAGE_HEIGHT_RST;
		cost_reg = TERMINAL_COST_RST;
		pen_reg = BAD_PENALTY_RST;
		left_px = '0;
		col_cnt = 0;
		row_cnt = 0;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			line_mem[i] = '0;
			line_filled[i] = 1'b0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_values();
		test_midframe_shrink();
		test_extreme_weights();
		test_width_clamp();
		test_height_extremes();
		test_random_phase(21, 66, 300);
		test_random_phase(66, 21, 300);
		test_random_phase(0, 0, 300);
		test_output_stall();

		wait_idle();
		repeat (5) @(posedge clk);
		errors += expected_q.size();
		$display("covered %0d pixels over %0d register settings, %0d results checked",
			items_sent, settings_used, results_checked);
		$display("%0d frame ends seen; widths 0..2047 incl. clamping, heights 0..65535, %s",
			frames_seen, "mid-frame changes and a long output stall");
		if (errors == 0) begin
			$display("tb_graph_cut_seam_edge_weights passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("tb_graph_cut_seam_edge_weights failed");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/gcs_pkg.sv
hw/rtl/gcs_ram.sv
hw/rtl/gcs_cost.sv
hw/rtl/graph_cut_seam_edge_weights.sv
test/tb_graph_cut_seam_edge_weights.sv
